// File: hw/rtl/quic_varint_codec_defines.svh
// Assertion macros used by the codec's checker file.
`ifndef QUIC_VARINT_CODEC_DEFINES_SVH
`define QUIC_VARINT_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QVC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qvc: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define QVC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qvc: next-cycle property violated");

`endif

// File: hw/rtl/qvc_pkg.sv
// Types and constants of the QUIC variable-length integer codec.
package qvc_pkg;

  localparam int unsigned ValueW = 62;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [63:0] MAX_1BYTE = 64'h0000_0000_0000_003F;
  localparam logic [63:0] MAX_2BYTE = 64'h0000_0000_0000_3FFF;
  localparam logic [63:0] MAX_4BYTE = 64'h0000_0000_3FFF_FFFF;
  localparam logic [63:0] MAX_8BYTE = 64'h3FFF_FFFF_FFFF_FFFF;

  // Two-bit length codes carried in the top of a varint's first byte.
  localparam logic [1:0] LEN_CODE_1 = 2'd0;
  localparam logic [1:0] LEN_CODE_2 = 2'd1;
  localparam logic [1:0] LEN_CODE_4 = 2'd2;
  localparam logic [1:0] LEN_CODE_8 = 2'd3;

  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DEC,
    JOB_ERR
  } job_kind_e;

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    job_kind_e         kind;
    logic [ValueW-1:0] value;
    logic [1:0]        len_code;
  } job_t;

  // One result item as it sits in the output register.
  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic [ValueW-1:0] value_out;
    logic              value_valid;
    logic [3:0]        enc_length;
    logic              is_last;
    logic              too_large;
  } res_t;

  function automatic logic [3:0] len_bytes(input logic [1:0] code);
    return 4'd1 << code;
  endfunction

endpackage

// File: hw/rtl/qvc_if.sv
// Valid/ready channel interfaces for the codec's input and result streams.
interface qvc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] value_in;
  logic [7:0]  in_byte;

  modport source (output valid, output cmd, output value_in, output in_byte, input ready);
  modport sink   (input valid, input cmd, input value_in, input in_byte, output ready);
endinterface

interface qvc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [61:0] value_out;
  logic        value_valid;
  logic [3:0]  enc_length;
  logic        is_last;
  logic        too_large;

  modport source (output valid, output out_byte, output byte_valid, output value_out,
                  output value_valid, output enc_length, output is_last,
                  output too_large, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input value_out,
                  input value_valid, input enc_length, input is_last,
                  input too_large, output ready);
endinterface

// File: hw/rtl/qvc_queue.sv
// Small job queue between the codec's front end and back end.
module qvc_queue
  import qvc_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output logic full_o,
  output logic head_valid_o,
  output job_t head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];

endmodule

// File: hw/rtl/qvc_front.sv
// Front end: accepts input items, sizes encodes and accumulates decode bytes.
module qvc_front
  import qvc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  qvc_in_if.sink   in_i,
  input  logic     q_full_i,
  output logic     push_o,
  output job_t     push_job_o
);

  logic [2:0]        dec_cnt_q, dec_cnt_d;
  logic [1:0]        dec_code_q, dec_code_d;
  logic [ValueW-1:0] dec_accum_q, dec_accum_d;

  logic              accept;
  logic [3:0]        cnt_next;
  logic [1:0]        code_use;
  logic [ValueW-1:0] accum_new;
  logic              dec_done;
  logic [1:0]        enc_code;
  job_t              enc_job;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  // Decode path: the first byte of a varint fixes its length.
  always_comb begin
    if (dec_cnt_q == 3'd0) begin
      cnt_next  = 4'd1;
      code_use  = in_i.in_byte[7:6];
      accum_new = {{(ValueW-6){1'b0}}, in_i.in_byte[5:0]};
    end else begin
      cnt_next  = {1'b0, dec_cnt_q} + 4'd1;
      code_use  = dec_code_q;
      accum_new = {dec_accum_q[ValueW-9:0], in_i.in_byte};
    end
    dec_done = (cnt_next >= len_bytes(code_use));
  end

  // Encode path: shortest length that holds the value.
  always_comb begin
    if (in_i.value_in <= MAX_1BYTE) begin
      enc_code = LEN_CODE_1;
    end else if (in_i.value_in <= MAX_2BYTE) begin
      enc_code = LEN_CODE_2;
    end else if (in_i.value_in <= MAX_4BYTE) begin
      enc_code = LEN_CODE_4;
    end else begin
      enc_code = LEN_CODE_8;
    end
    if (in_i.value_in > MAX_8BYTE) begin
      enc_job.kind     = JOB_ERR;
      enc_job.value    = '0;
      enc_job.len_code = LEN_CODE_1;
    end else begin
      enc_job.kind     = JOB_ENC;
      enc_job.value    = in_i.value_in[ValueW-1:0];
      enc_job.len_code = enc_code;
    end
  end

  always_comb begin
    push_o     = 1'b0;
    push_job_o = enc_job;
    dec_cnt_d   = dec_cnt_q;
    dec_code_d  = dec_code_q;
    dec_accum_d = dec_accum_q;
    if (accept) begin
      if (in_i.cmd == CMD_ENCODE) begin
        push_o = 1'b1;
      end else begin
        push_job_o.kind     = JOB_DEC;
        push_job_o.value    = accum_new;
        push_job_o.len_code = code_use;
        if (dec_done) begin
          push_o      = 1'b1;
          dec_cnt_d   = 3'd0;
          dec_code_d  = LEN_CODE_1;
          dec_accum_d = '0;
        end else begin
          dec_cnt_d   = cnt_next[2:0];
          dec_code_d  = code_use;
          dec_accum_d = accum_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_cnt_q   <= 3'd0;
      dec_code_q  <= LEN_CODE_1;
      dec_accum_q <= '0;
    end else begin
      dec_cnt_q   <= dec_cnt_d;
      dec_code_q  <= dec_code_d;
      dec_accum_q <= dec_accum_d;
    end
  end

endmodule

// File: hw/rtl/qvc_back.sv
// Back end: queued jobs become output-register results, one per cycle unless stalled.
module qvc_back
  import qvc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_job_i,
  output logic      pop_o,
  qvc_out_if.source out_o
);

  logic [2:0]  idx_q, idx_d;
  logic        out_vld_q, out_vld_d;
  res_t        res_q, res_d;

  logic        load;
  logic        last;
  logic [3:0]  nbytes;
  logic [2:0]  last_idx;
  logic [2:0]  sel;
  logic [63:0] padded;
  logic [7:0]  enc_byte;

  assign nbytes   = len_bytes(head_job_i.len_code);
  assign last_idx = 3'(nbytes - 4'd1);
  assign sel      = last_idx - idx_q;
  assign padded   = {2'b00, head_job_i.value};

  always_comb begin
    enc_byte = padded[{sel, 3'b000} +: 8];
    if (idx_q == 3'd0) begin
      enc_byte[7:6] = enc_byte[7:6] | head_job_i.len_code;
    end
  end

  assign last = (head_job_i.kind != JOB_ENC) || (idx_q == last_idx);
  assign load = head_valid_i && (!out_vld_q || out_o.ready);
  assign pop_o = load && last;

  always_comb begin
    res_d = '0;
    case (head_job_i.kind)
      JOB_ENC: begin
        res_d.out_byte   = enc_byte;
        res_d.byte_valid = 1'b1;
        res_d.enc_length = nbytes;
        res_d.is_last    = last;
      end
      JOB_DEC: begin
        res_d.value_out   = head_job_i.value;
        res_d.value_valid = 1'b1;
        res_d.enc_length  = nbytes;
        res_d.is_last     = 1'b1;
      end
      JOB_ERR: begin
        res_d.too_large = 1'b1;
        res_d.is_last   = 1'b1;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_comb begin
    idx_d     = idx_q;
    out_vld_d = out_vld_q;
    if (load) begin
      idx_d     = last ? 3'd0 : idx_q + 3'd1;
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= 3'd0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_byte    = res_q.out_byte;
  assign out_o.byte_valid  = res_q.byte_valid;
  assign out_o.value_out   = res_q.value_out;
  assign out_o.value_valid = res_q.value_valid;
  assign out_o.enc_length  = res_q.enc_length;
  assign out_o.is_last     = res_q.is_last;
  assign out_o.too_large   = res_q.too_large;

endmodule

// File: hw/rtl/quic_varint_codec.sv
// Top level of the QUIC variable-length integer codec.
//
//   Channel  Direction  Carries
//   in_i     sink       cmd, value_in (encode), in_byte (decode)
//   out_o    source     out_byte, byte_valid, value_out, value_valid,
//                       enc_length, is_last, too_large
//
// A decode byte is folded by the front end into the running value, and a job
// is queued only when a varint completes. An encode item yields 1, 2, 4 or 8
// results, one per emitted byte, each through the back end's single output
// register; an oversized value yields a single error result.
// Reset clears the decode state, the job queue and the output valid flag.
// The input stalls only while the job queue is full; the output register
// holds its result until the sink takes it and refills in the same cycle.
module quic_varint_codec
  import qvc_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qvc_in_if.sink    in_i,
  qvc_out_if.source out_o
);

  // Queue signals between front and back ends.
  logic q_push;
  job_t q_push_job;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  job_t q_head_job;

  // The front end sizes encodes and collects decode bytes; it never waits on
  // the output side except through a full queue.
  qvc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_job_o (q_push_job)
  );

  // Jobs wait here in arrival order, so encode and decode results keep the
  // order of the items that caused them.
  qvc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_job_i   (q_push_job),
    .pop_i        (q_pop),
    .full_o       (q_full),
    .head_valid_o (q_head_valid),
    .head_job_o   (q_head_job)
  );

  // The back end walks the head job one result per transfer and retires it
  // with the last one.
  qvc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_job_i   (q_head_job),
    .pop_o        (q_pop),
    .out_o        (out_o)
  );

endmodule

// File: hw/rtl/qvc_checker.sv
// Port-level checks of the codec's result stream, bound to the top level.
`include "quic_varint_codec_defines.svh"

module qvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        byte_valid_i,
  input logic [61:0] value_out_i,
  input logic        value_valid_i,
  input logic [3:0]  enc_length_i,
  input logic        is_last_i,
  input logic        too_large_i
);

  // A result that waits keeps its contents.
  `QVC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({out_byte_i, byte_valid_i, value_out_i, value_valid_i, enc_length_i, is_last_i, too_large_i}))

  // Every result is exactly one of byte, value or error.
  `QVC_ASSERT_IMP(a_one_kind, clk_i, rst_ni, out_valid_i, $onehot({byte_valid_i, value_valid_i, too_large_i}))

  // An error result is the only result of its item and carries nothing else.
  `QVC_ASSERT_IMP(a_err_clean, clk_i, rst_ni, out_valid_i && too_large_i, is_last_i && (enc_length_i == 4'd0) && (out_byte_i == 8'd0) && (value_out_i == 62'd0))

  // A byte that is not the last one belongs to a multi-byte varint.
  `QVC_ASSERT_IMP(a_multi_len, clk_i, rst_ni, out_valid_i && byte_valid_i && !is_last_i, (enc_length_i == 4'd2) || (enc_length_i == 4'd4) || (enc_length_i == 4'd8))

endmodule

bind quic_varint_codec qvc_checker u_qvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .byte_valid_i  (out_o.byte_valid),
  .value_out_i   (out_o.value_out),
  .value_valid_i (out_o.value_valid),
  .enc_length_i  (out_o.enc_length),
  .is_last_i     (out_o.is_last),
  .too_large_i   (out_o.too_large)
);

// File: sim/quic_varint_codec_tb.sv
// Self-checking testbench for the QUIC varint codec: encode and decode traffic against a predictor.
`timescale 1ns / 100ps

module quic_varint_codec_tb;
  import qvc_pkg::*;

  // The watchdog ends the run after this many cycles without a transfer on either
  // channel. The slowest correct case is a sender gap plus a sink stretch in its
  // slow mode, so this limit is far beyond any legal stall.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles to keep watching the result channel once nothing is outstanding. The back
  // end holds at most a short queue and one output register, so this is generous.
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 245;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_RANDOM,
    SINK_SLOW
  } sink_mode_e;

  logic clk_i;
  logic rst_ni;

  qvc_in_if  in_ch ();
  qvc_out_if out_ch ();

  quic_varint_codec dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Results the codec still owes, oldest first.
  res_t codec_results_due[$];
  res_t due_result;

  // Decoder state as the predictor sees it: bytes taken of the varint in progress,
  // its length in bytes, and the value gathered so far.
  int unsigned       rx_count  = 0;
  int unsigned       rx_length = 0;
  logic [ValueW-1:0] rx_value  = '0;

  int         error_count     = 0;
  int         idle_cycles     = 0;
  int         burst_left      = 0;
  sink_mode_e sink_mode       = SINK_STEADY;
  int         sink_phase_left = 0;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Works out what one accepted input item must produce and appends it to the
  // queue of results due. An encode yields one result per byte, or a single error
  // result when the value does not fit in 62 bits. A decode byte only yields a
  // result when it completes a varint.
  function void compute_codec_results(input logic cmd, input logic [63:0] value,
                                      input logic [7:0] byte_in);
    res_t        r;
    int unsigned nbytes;
    logic [7:0]  len_flag;
    if (cmd == CMD_ENCODE) begin
      if (value > MAX_8BYTE) begin
        r = '0;
        r.is_last = 1'b1;
        r.too_large = 1'b1;
        codec_results_due.push_back(r);
        return;
      end
      // A value sitting exactly on a bound still takes the shorter length.
      if (value <= MAX_1BYTE) begin
        nbytes = 1;
        len_flag = {LEN_CODE_1, 6'b0};
      end else if (value <= MAX_2BYTE) begin
        nbytes = 2;
        len_flag = {LEN_CODE_2, 6'b0};
      end else if (value <= MAX_4BYTE) begin
        nbytes = 4;
        len_flag = {LEN_CODE_4, 6'b0};
      end else begin
        nbytes = 8;
        len_flag = {LEN_CODE_8, 6'b0};
      end
      for (int k = 0; k < nbytes; k++) begin
        r = '0;
        r.out_byte = 8'(value >> (8 * (nbytes - 1 - k)));
        if (k == 0) begin
          r.out_byte = r.out_byte | len_flag;
        end
        r.byte_valid = 1'b1;
        r.enc_length = 4'(nbytes);
        r.is_last = (k == nbytes - 1);
        codec_results_due.push_back(r);
      end
    end else begin
      if (rx_count == 0) begin
        // The first byte's top two bits give the length; the rest is value.
        rx_length = 1 << byte_in[7:6];
        rx_value = ValueW'(byte_in[5:0]);
        rx_count = 1;
      end else begin
        rx_value = {rx_value[ValueW-9:0], byte_in};
        rx_count++;
      end
      if (rx_count >= rx_length) begin
        r = '0;
        r.value_out = rx_value;
        r.value_valid = 1'b1;
        r.enc_length = 4'(rx_length);
        r.is_last = 1'b1;
        codec_results_due.push_back(r);
        rx_count = 0;
        rx_length = 0;
        rx_value = '0;
      end
    end
  endfunction

  // Offers one item on the input channel and returns once it has been transferred.
  // The sender runs in bursts: when a burst is used up it may sit idle for a random
  // gap before the next one starts. The field that the command does not use
  // carries random data, since the codec must ignore it.
  task automatic send_item(input logic cmd, input logic [63:0] value, input logic [7:0] byte_in);
    int          gap;
    logic [63:0] drive_value;
    logic [7:0]  drive_byte;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    drive_value = (cmd == CMD_ENCODE) ? value : rand64();
    drive_byte = (cmd == CMD_DECODE) ? byte_in : 8'($urandom);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.value_in <= drive_value;
    in_ch.in_byte <= drive_byte;
    // Ready is sampled as it stood before the edge, so the transfer is seen exactly
    // at the edge where valid and ready were both high.
    do @(posedge clk_i); while (!in_ch.ready);
    compute_codec_results(cmd, drive_value, drive_byte);
  endtask

  // Values at each side of every length bound, the largest legal value, and two
  // oversized values, one with only bit 62 set and one with every bit set.
  task automatic test_encode_bounds();
    send_item(CMD_ENCODE, 64'd0, 8'h00);
    send_item(CMD_ENCODE, MAX_1BYTE, 8'h00);
    send_item(CMD_ENCODE, MAX_1BYTE + 1, 8'h00);
    send_item(CMD_ENCODE, MAX_2BYTE, 8'h00);
    send_item(CMD_ENCODE, MAX_2BYTE + 1, 8'h00);
    send_item(CMD_ENCODE, MAX_4BYTE, 8'h00);
    send_item(CMD_ENCODE, MAX_4BYTE + 1, 8'h00);
    send_item(CMD_ENCODE, MAX_8BYTE, 8'h00);
    send_item(CMD_ENCODE, MAX_8BYTE + 1, 8'h00);
    send_item(CMD_ENCODE, '1, 8'h00);
  endtask

  // One varint of each length. The four-byte one has an oversized encode in the
  // middle of it, which must leave the partial decode alone. The eight-byte one is
  // all ones and decodes to the largest value.
  task automatic test_decode_lengths();
    send_item(CMD_DECODE, '0, 8'h00);
    send_item(CMD_DECODE, '0, 8'h7B);
    send_item(CMD_DECODE, '0, 8'hBD);
    send_item(CMD_DECODE, '0, 8'h9D);
    send_item(CMD_DECODE, '0, 8'h7F);
    send_item(CMD_ENCODE, 64'h4000_0000_0000_0000, 8'h00);
    send_item(CMD_DECODE, '0, 8'h3E);
    send_item(CMD_DECODE, '0, 8'h7D);
    repeat (8) send_item(CMD_DECODE, '0, 8'hFF);
  endtask

  // Mostly well-formed work: encodes of values spread over every magnitude, and
  // complete varints with random content, sometimes with an encode slipped in
  // between their bytes. The rest is noise: stray decode bytes that knock the
  // decoder out of step, and encodes of raw 64-bit values, mostly oversized.
  task automatic test_random_traffic();
    int          sent;
    int unsigned nbytes;
    int unsigned slot;
    logic [1:0]  code;
    logic [63:0] value;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // Shifting a random word by a random amount gives every length a fair share.
          value = rand64() >> $urandom_range(0, 63);
          send_item(CMD_ENCODE, value, 8'h00);
          sent++;
        end
        4, 5, 6, 7: begin
          code = 2'($urandom);
          nbytes = 1 << code;
          slot = ($urandom_range(0, 3) == 0) ? $urandom_range(1, nbytes) : nbytes + 1;
          for (int k = 0; k < nbytes; k++) begin
            if (k == slot) begin
              send_item(CMD_ENCODE, rand64() >> $urandom_range(0, 63), 8'h00);
              sent++;
            end
            send_item(CMD_DECODE, '0, (k == 0) ? {code, 6'($urandom)} : 8'($urandom));
            sent++;
          end
        end
        8: begin
          send_item(CMD_DECODE, '0, 8'($urandom));
          sent++;
        end
        default: begin
          send_item(CMD_ENCODE, rand64(), 8'h00);
          sent++;
        end
      endcase
    end
  endtask

  function void check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Every result transfer is matched against the oldest result due.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (codec_results_due.size() == 0) begin
        $display("%0t: result transfer with nothing expected, out_byte 0x%0h value_out 0x%0h",
                 $time, out_ch.out_byte, out_ch.value_out);
        error_count++;
      end else begin
        due_result = codec_results_due.pop_front();
        check_field("out_byte", due_result.out_byte, out_ch.out_byte);
        check_field("byte_valid", due_result.byte_valid, out_ch.byte_valid);
        check_field("value_out", due_result.value_out, out_ch.value_out);
        check_field("value_valid", due_result.value_valid, out_ch.value_valid);
        check_field("enc_length", due_result.enc_length, out_ch.enc_length);
        check_field("is_last", due_result.is_last, out_ch.is_last);
        check_field("too_large", due_result.too_large, out_ch.too_large);
      end
    end
  end

  // The sink switches between stretches of steady acceptance, coin-flip stalls and
  // slow acceptance, so stalls land on every byte of a multi-byte encode.
  always @(posedge clk_i) begin
    if (sink_phase_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 2));
      sink_phase_left <= $urandom_range(8, 60);
    end else begin
      sink_phase_left <= sink_phase_left - 1;
    end
    case (sink_mode)
      SINK_STEADY: out_ch.ready <= 1'b1;
      SINK_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
      default:     out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results still due",
               $time, idle_cycles, codec_results_due.size());
      $display("quic_varint_codec verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_ENCODE;
    in_ch.value_in <= '0;
    in_ch.in_byte <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_encode_bounds();
    test_decode_lengths();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (codec_results_due.size() != 0) @(posedge clk_i);
    // Anything that shows up after this point has no expectation and is flagged.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("quic_varint_codec verification clean");
    end else begin
      $display("quic_varint_codec verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/qvc_pkg.sv
hw/rtl/qvc_if.sv
hw/rtl/qvc_queue.sv
hw/rtl/qvc_front.sv
hw/rtl/qvc_back.sv
hw/rtl/quic_varint_codec.sv
hw/rtl/qvc_checker.sv
sim/quic_varint_codec_tb.sv
